FILE: design/dld_pkg.sv
// ----------------------------------------------------------------------------
// dld_pkg
// Shared constants for the bounded linked deque: operation kinds, status
// codes and default sizes.
// ----------------------------------------------------------------------------
package dld_pkg;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_WORD_BITS = 32;
    localparam int KIND_W        = 3;
    localparam int STATUS_W      = 2;

    // operation kinds
    localparam logic [KIND_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] OP_POP_AT     = 3'd4;
    localparam logic [KIND_W-1:0] OP_REVERSE    = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

FILE: design/dld_if.sv
// ----------------------------------------------------------------------------
// dld_in_if / dld_out_if
// Valid/ready channels carrying operation items in and result items out.
// ----------------------------------------------------------------------------
interface dld_in_if #(
    parameter int WORD_BITS = dld_pkg::DEF_WORD_BITS,
    parameter int CAPACITY  = dld_pkg::DEF_CAPACITY
);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                        valid;
    logic                        ready;
    logic [dld_pkg::KIND_W-1:0]  kind;
    logic [WORD_BITS-1:0]        value;
    logic [CW-1:0]               position;

    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

interface dld_out_if #(
    parameter int WORD_BITS = dld_pkg::DEF_WORD_BITS,
    parameter int CAPACITY  = dld_pkg::DEF_CAPACITY
);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                          valid;
    logic                          ready;
    logic [dld_pkg::STATUS_W-1:0]  status;
    logic [WORD_BITS-1:0]          popped;
    logic [CW-1:0]                 count;

    modport source (output valid, status, popped, count, input ready);
    modport sink   (input valid, status, popped, count, output ready);
endinterface

FILE: design/dld_store.sv
// ----------------------------------------------------------------------------
// dld_store
// Node store: data words plus forward and backward links, each a
// synchronous memory with one registered read port and one write port.
// ----------------------------------------------------------------------------
module dld_store #(
    parameter int CAPACITY  = dld_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = dld_pkg::DEF_WORD_BITS,
    parameter int AW        = $clog2(CAPACITY),
    parameter int NW        = $clog2(CAPACITY + 1)
) (
    input  logic                 clk,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_word,
    output logic [NW-1:0]        rd_fwd,
    output logic [NW-1:0]        rd_bwd,
    input  logic                 word_we,
    input  logic [AW-1:0]        word_addr,
    input  logic [WORD_BITS-1:0] word_data,
    input  logic                 fwd_we,
    input  logic [AW-1:0]        fwd_addr,
    input  logic [NW-1:0]        fwd_data,
    input  logic                 bwd_we,
    input  logic [AW-1:0]        bwd_addr,
    input  logic [NW-1:0]        bwd_data
);
    logic [WORD_BITS-1:0] word_mem [CAPACITY];
    logic [NW-1:0]        fwd_mem  [CAPACITY];
    logic [NW-1:0]        bwd_mem  [CAPACITY];

    // write ports
    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_addr] <= word_data;
        end
        if (fwd_we)
        begin
            fwd_mem[fwd_addr] <= fwd_data;
        end
        if (bwd_we)
        begin
            bwd_mem[bwd_addr] <= bwd_data;
        end
    end

    // registered read of one whole node
    always_ff @(posedge clk)
    begin
        rd_word <= word_mem[rd_addr];
        rd_fwd  <= fwd_mem[rd_addr];
        rd_bwd  <= bwd_mem[rd_addr];
    end
endmodule

FILE: design/bounded_linked_deque.sv
// ----------------------------------------------------------------------------
// bounded_linked_deque
// Deque kept as a doubly linked list in a node store of CAPACITY entries,
// driven by a read/modify/write sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | kind, value, position
//  out_ch  | out | status, popped, count
//
//  One item at a time. A push takes an unused node from the fill counter
//  or reads one off the free chain first; a pop reads its node, unlinks it
//  and returns it to the free chain. Pop at position first walks fewer than
//  CAPACITY/2 links from the nearer end. Reverse and failing items skip the store.
//  No clearing pass: unused nodes are handed out by a fill counter.
//  A stalled result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module bounded_linked_deque #(
    parameter int CAPACITY  = dld_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = dld_pkg::DEF_WORD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    dld_in_if.sink     in_ch,
    dld_out_if.source  out_ch
);
    import dld_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam logic [NW-1:0] NUL = NW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_W1   = 3'd3;
    localparam logic [2:0] S_W2   = 3'd4;
    localparam logic [2:0] S_PW1  = 3'd5;
    localparam logic [2:0] S_PW2  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [NW-1:0]        end0_reg, end0_next;
    logic [NW-1:0]        end1_reg, end1_next;
    logic [NW-1:0]        free_head_reg, free_head_next;
    logic [NW-1:0]        fresh_reg, fresh_next;
    logic [NW-1:0]        count_reg, count_next;
    logic                 rev_reg, rev_next;
    logic [NW-1:0]        node_reg, node_next;
    logic [NW-1:0]        lf_reg, lf_next;
    logic [NW-1:0]        lb_reg, lb_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 dir_reg, dir_next;
    logic [NW-1:0]        steps_reg, steps_next;
    logic                 push_reg, push_next;
    logic                 pop_reg, pop_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [WORD_BITS-1:0] out_popped_reg, out_popped_next;
    logic [NW-1:0]        out_count_reg, out_count_next;

    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_word;
    logic [NW-1:0]        rd_fwd, rd_bwd;
    logic                 word_we, fwd_we, bwd_we;
    logic [AW-1:0]        word_addr, fwd_addr, bwd_addr;
    logic [WORD_BITS-1:0] word_data;
    logic [NW-1:0]        fwd_data, bwd_data;

    logic                 fe;
    logic                 push_end;
    logic [NW-1:0]        old_end;
    logic [NW-1:0]        walk_next;

    dld_store #(
        .CAPACITY (CAPACITY),
        .WORD_BITS(WORD_BITS),
        .AW       (AW),
        .NW       (NW)
    ) u_store (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_word  (rd_word),
        .rd_fwd   (rd_fwd),
        .rd_bwd   (rd_bwd),
        .word_we  (word_we),
        .word_addr(word_addr),
        .word_data(word_data),
        .fwd_we   (fwd_we),
        .fwd_addr (fwd_addr),
        .fwd_data (fwd_data),
        .bwd_we   (bwd_we),
        .bwd_addr (bwd_addr),
        .bwd_data (bwd_data)
    );

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = out_status_reg;
    assign out_ch.popped = out_popped_reg;
    assign out_ch.count  = out_count_reg;

    assign fe        = rev_reg;
    assign push_end  = (in_ch.kind == OP_PUSH_FRONT) ? fe : ~fe;
    assign old_end   = dir_reg ? end1_reg : end0_reg;
    assign walk_next = dir_reg ? rd_bwd : rd_fwd;

    // sequence one item through read, walk and write-back steps
    always_comb
    begin
        state_next      = state_reg;
        end0_next       = end0_reg;
        end1_next       = end1_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        node_next       = node_reg;
        lf_next         = lf_reg;
        lb_next         = lb_reg;
        word_next       = word_reg;
        dir_next        = dir_reg;
        steps_next      = steps_reg;
        push_next       = push_reg;
        pop_next        = pop_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_popped_next = out_popped_reg;
        out_count_next  = out_count_reg;
        rd_addr         = node_reg[AW-1:0];
        word_we         = 1'b0;
        fwd_we          = 1'b0;
        bwd_we          = 1'b0;
        word_addr       = node_reg[AW-1:0];
        fwd_addr        = node_reg[AW-1:0];
        bwd_addr        = node_reg[AW-1:0];
        word_data       = word_reg;
        fwd_data        = NUL;
        bwd_data        = NUL;

        // drop a result the sink has taken
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    status_next = ST_OK;
                    push_next   = 1'b0;
                    pop_next    = 1'b0;
                    steps_next  = '0;
                    word_next   = in_ch.value;
                    state_next  = S_DONE;
                    case (in_ch.kind)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (count_reg == NUL)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                push_next = 1'b1;
                                dir_next  = push_end;
                                if (fresh_reg != NUL)
                                begin
                                    node_next  = fresh_reg;
                                    fresh_next = fresh_reg + NW'(1);
                                    state_next = S_PW1;
                                end
                                else
                                begin
                                    node_next  = free_head_reg;
                                    state_next = S_RD;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pop_next   = 1'b1;
                                node_next  = ((in_ch.kind == OP_POP_FRONT) ? fe : ~fe)
                                             ? end1_reg : end0_reg;
                                state_next = S_RD;
                            end
                        end
                        OP_POP_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (in_ch.position == '0 || in_ch.position > count_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                pop_next   = 1'b1;
                                state_next = S_RD;
                                // walk from the nearer end
                                if (in_ch.position > (count_reg >> 1))
                                begin
                                    dir_next   = ~fe;
                                    node_next  = fe ? end0_reg : end1_reg;
                                    steps_next = count_reg - in_ch.position;
                                end
                                else
                                begin
                                    dir_next   = fe;
                                    node_next  = fe ? end1_reg : end0_reg;
                                    steps_next = in_ch.position - NW'(1);
                                end
                            end
                        end
                        OP_REVERSE:
                        begin
                            rev_next = ~rev_reg;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                rd_addr    = node_reg[AW-1:0];
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    if (push_reg)
                    begin
                        // node taken off the free chain
                        free_head_next = rd_fwd;
                        state_next     = S_PW1;
                    end
                    else
                    begin
                        lf_next    = rd_fwd;
                        lb_next    = rd_bwd;
                        word_next  = rd_word;
                        state_next = S_W1;
                    end
                end
                else
                begin
                    // advance one link per cycle
                    node_next  = walk_next;
                    rd_addr    = walk_next[AW-1:0];
                    steps_next = steps_reg - NW'(1);
                end
            end

            S_W1:
            begin
                // unlink the node from its neighbors
                if (lb_reg != NUL)
                begin
                    fwd_we   = 1'b1;
                    fwd_addr = lb_reg[AW-1:0];
                    fwd_data = lf_reg;
                end
                else
                begin
                    end0_next = lf_reg;
                end
                if (lf_reg != NUL)
                begin
                    bwd_we   = 1'b1;
                    bwd_addr = lf_reg[AW-1:0];
                    bwd_data = lb_reg;
                end
                else
                begin
                    end1_next = lb_reg;
                end
                state_next = S_W2;
            end

            S_W2:
            begin
                // return the node to the free chain
                fwd_we         = 1'b1;
                fwd_addr       = node_reg[AW-1:0];
                fwd_data       = free_head_reg;
                free_head_next = node_reg;
                count_next     = count_reg - NW'(1);
                state_next     = S_DONE;
            end

            S_PW1:
            begin
                // fill the new node and hook it in at the chosen end
                word_we    = 1'b1;
                fwd_we     = 1'b1;
                bwd_we     = 1'b1;
                fwd_data   = dir_reg ? NUL : old_end;
                bwd_data   = dir_reg ? old_end : NUL;
                lf_next    = old_end;
                count_next = count_reg + NW'(1);
                if (dir_reg)
                begin
                    end1_next = node_reg;
                end
                else
                begin
                    end0_next = node_reg;
                end
                if (old_end != NUL)
                begin
                    state_next = S_PW2;
                end
                else
                begin
                    if (dir_reg)
                    begin
                        end0_next = node_reg;
                    end
                    else
                    begin
                        end1_next = node_reg;
                    end
                    state_next = S_DONE;
                end
            end

            S_PW2:
            begin
                // point the old end node back at the new one
                if (dir_reg)
                begin
                    fwd_we   = 1'b1;
                    fwd_addr = lf_reg[AW-1:0];
                    fwd_data = node_reg;
                end
                else
                begin
                    bwd_we   = 1'b1;
                    bwd_addr = lf_reg[AW-1:0];
                    bwd_data = node_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_popped_next = pop_reg ? word_reg : '0;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            end0_reg      <= NUL;
            end1_reg      <= NUL;
            free_head_reg <= NUL;
            fresh_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            push_reg      <= 1'b0;
            pop_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end0_reg      <= end0_next;
            end1_reg      <= end1_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            push_reg      <= push_next;
            pop_reg       <= pop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        lf_reg         <= lf_next;
        lb_reg         <= lb_next;
        word_reg       <= word_next;
        dir_reg        <= dir_next;
        steps_reg      <= steps_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_popped_reg <= out_popped_next;
        out_count_reg  <= out_count_next;
    end
endmodule

FILE: design/dld_checker.sv
// ----------------------------------------------------------------------------
// dld_checker
// Port-level checks on the bounded linked deque, bound to the top level.
// ----------------------------------------------------------------------------
module dld_checker #(
    parameter int CAPACITY  = dld_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = dld_pkg::DEF_WORD_BITS,
    parameter int CW        = $clog2(CAPACITY + 1)
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dld_pkg::STATUS_W-1:0]  out_status,
    input logic [WORD_BITS-1:0]          out_popped,
    input logic [CW-1:0]                 out_count
);
    import dld_pkg::*;

    // one item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while previous item in progress");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
            && $stable(out_popped) && $stable(out_count)))
        else $error("stalled result changed");

    // count stays within capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_count <= CW'(CAPACITY)))
        else $error("count beyond capacity");

    // failed items carry no word
    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != ST_OK) |-> (out_popped == '0))
        else $error("nonzero word on failed item");

    // full only when the store is full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status == ST_FULL) |-> (out_count == CW'(CAPACITY)))
        else $error("full status with free nodes");
endmodule

bind bounded_linked_deque dld_checker #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(WORD_BITS)
) u_dld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_status(out_ch.status),
    .out_popped(out_ch.popped),
    .out_count (out_ch.count)
);
